[rtl/core/melody_string_tone_player_assert.svh]
// Assertion macros for the melody player checker.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef MELODY_STRING_TONE_PLAYER_ASSERT_SVH
`define MELODY_STRING_TONE_PLAYER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define MSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("melody player check failed in the same cycle");

// Consequent in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("melody player check failed one cycle later");

`endif

[rtl/core/msp_pkg.sv]
// Shared types, constants and decode functions of the melody player.
// Used by every module of the block; depends on nothing.
`default_nettype none

package msp_pkg;

	localparam int PERIOD_W  = 12;
	localparam int DUR_MS_W  = 12;
	localparam int DUR_US_W  = 22;
	localparam int PAUSE_W   = 5;
	localparam int HALF_W    = 11;
	localparam int US_W      = 10;
	localparam int DEF_DUR_W = 11;
	localparam int STEP_W    = 8;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [US_W:0] US_PER_MS = 11'd1000;

	localparam logic [DEF_DUR_W-1:0] DEFAULT_DUR_RST = 11'd400;
	localparam logic [STEP_W-1:0]    DUR_STEP_RST    = 8'd200;

	// Register indexes on the configuration port.
	localparam logic REG_DEFAULT_DUR = 1'b0;
	localparam logic REG_DUR_STEP    = 1'b1;

	// Song characters.
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_G  = 8'h47;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_G  = 8'h67;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [PAUSE_W-1:0] PAUSE_NONE  = 5'd0;
	localparam logic [PAUSE_W-1:0] PAUSE_SHORT = 5'd5;
	localparam logic [PAUSE_W-1:0] PAUSE_MID   = 5'd20;
	localparam logic [PAUSE_W-1:0] PAUSE_LONG  = 5'd30;

	// Tone periods in microseconds: upper-case octave first, then lower case.
	localparam logic [PERIOD_W-1:0] TONE_TABLE [0:13] = '{
		12'd2272, 12'd2024, 12'd3816, 12'd3401, 12'd3030, 12'd2865, 12'd2551,
		12'd1136, 12'd1012, 12'd1912, 12'd1703, 12'd1517, 12'd1432, 12'd1275
	};

	typedef struct packed {
		logic       operation;
		logic [7:0] song_byte;
	} item_t;

	typedef struct packed {
		logic speaker_level;
		logic busy_res;
		logic byte_rejected;
	} result_t;

	typedef struct packed {
		logic [DEF_DUR_W-1:0] default_dur_ms;
		logic [STEP_W-1:0]    dur_step_ms;
	} cfg_t;

	// A classified transaction as it travels from the front end to the back end.
	typedef struct packed {
		logic                tick;
		logic                end_mark;
		logic [PERIOD_W-1:0] period_us;
		logic [DUR_MS_W-1:0] dur_ms;
		logic [DUR_US_W-1:0] dur_us;
		logic [PAUSE_W-1:0]  pause_ms;
	} cls_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_REST,
		PH_PAUSE
	} phase_t;

	typedef enum logic [1:0] {
		POS_NOTE,
		POS_DUR,
		POS_PAUSE
	} grp_pos_t;

	function automatic logic [PERIOD_W-1:0] tone_period(input logic [7:0] b);
		logic [7:0]          off;
		logic [PERIOD_W-1:0] p;
		off = 8'd0;
		p   = '0;
		if (b >= CH_UP_A && b <= CH_UP_G) begin
			off = b - CH_UP_A;
			p   = TONE_TABLE[off[3:0]];
		end else if (b >= CH_LO_A && b <= CH_LO_G) begin
			off = b - CH_LO_A + 8'd7;
			p   = TONE_TABLE[off[3:0]];
		end
		return p;
	endfunction

	function automatic logic [PAUSE_W-1:0] pause_length(input logic [7:0] b);
		logic [PAUSE_W-1:0] p;
		unique case (b)
			CH_PLUS:  p = PAUSE_NONE;
			CH_DOT:   p = PAUSE_MID;
			CH_UNDER: p = PAUSE_LONG;
			default:  p = PAUSE_SHORT;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

[rtl/core/msp_regs.sv]
// Configuration registers of the melody player behind a simple APB-style port.
// Depends on msp_pkg for the register indexes and reset values.
`default_nettype none

module msp_regs
	import msp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        reg_index,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [DEF_DUR_W-1:0] default_dur_q;
	logic [STEP_W-1:0]    dur_step_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_dur_q <= DEFAULT_DUR_RST;
			dur_step_q    <= DUR_STEP_RST;
		end else if (wr_en) begin
			unique case (reg_index)
				REG_DEFAULT_DUR: default_dur_q <= pwdata[DEF_DUR_W-1:0];
				REG_DUR_STEP:    dur_step_q    <= pwdata[STEP_W-1:0];
				default:         default_dur_q <= default_dur_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_DEFAULT_DUR: prdata = 32'(default_dur_q);
			REG_DUR_STEP:    prdata = 32'(dur_step_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.default_dur_ms = default_dur_q;
	assign cfg.dur_step_ms    = dur_step_q;

endmodule

`default_nettype wire

[rtl/core/msp_front.sv]
// Front end of the melody player: accepts transactions and classifies song bytes
// in two pipeline stages. Depends on msp_pkg for types and decode functions.
`default_nettype none

module msp_front
	import msp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output logic       cls_valid,
	input  wire logic  cls_ready,
	output cls_t       cls
);

	logic                valid_s1;
	logic                tick_s1;
	logic                end_mark_s1;
	logic [PERIOD_W-1:0] period_s1;
	logic [DUR_MS_W-1:0] dur_ms_s1;
	logic [PAUSE_W-1:0]  pause_s1;

	logic valid_s2;
	cls_t cls_s2;

	logic                adv_s1;
	logic                adv_s2;
	logic [7:0]          digit;
	logic [DUR_MS_W-1:0] dur_ms;

	assign adv_s2     = !valid_s2 || cls_ready;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item_ready = adv_s1;

	// A digit scales the step; anything else takes the default length.
	assign digit = item.song_byte - CH_0;

	always_comb begin
		if (item.song_byte >= CH_0 && item.song_byte <= CH_9) begin
			dur_ms = DUR_MS_W'(digit[3:0]) * DUR_MS_W'(cfg.dur_step_ms);
		end else begin
			dur_ms = DUR_MS_W'(cfg.default_dur_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= item_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			tick_s1     <= item.operation;
			end_mark_s1 <= (item.song_byte == 8'd0);
			period_s1   <= tone_period(item.song_byte);
			dur_ms_s1   <= dur_ms;
			pause_s1    <= pause_length(item.song_byte);
		end
		if (adv_s2 && valid_s1) begin
			cls_s2.tick      <= tick_s1;
			cls_s2.end_mark  <= end_mark_s1;
			cls_s2.period_us <= period_s1;
			cls_s2.dur_ms    <= dur_ms_s1;
			cls_s2.dur_us    <= DUR_US_W'(dur_ms_s1) * DUR_US_W'(US_PER_MS);
			cls_s2.pause_ms  <= pause_s1;
		end
	end

	assign cls_valid = valid_s2;
	assign cls       = cls_s2;

endmodule

`default_nettype wire

[rtl/core/msp_queue.sv]
// Short first-in first-out queue of classified transactions between the two ends.
// Depends on msp_pkg for the entry type.
`default_nettype none

module msp_queue
	import msp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cls_t push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cls_t      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cls_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/msp_back.sv]
// Back end of the melody player: group assembly, tone and pause timing, and the
// result register. Depends on msp_pkg for types and constants.
`default_nettype none

module msp_back
	import msp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cls_valid,
	output logic      cls_ready,
	input  wire cls_t cls,
	output logic      result_valid,
	input  wire logic result_ready,
	output result_t   result
);

	phase_t              phase_q, phase_d;
	grp_pos_t            pos_q, pos_d;
	logic                pin_q, pin_d;
	logic [PERIOD_W-1:0] period_q, period_d;
	logic [DUR_MS_W-1:0] dur_ms_q, dur_ms_d;
	logic [DUR_US_W-1:0] dur_us_q, dur_us_d;
	logic [PAUSE_W-1:0]  pause_q, pause_d;
	logic [HALF_W-1:0]   half_q, half_d;
	logic [DUR_US_W-1:0] elapsed_q, elapsed_d;
	logic [US_W-1:0]     us_q, us_d;
	logic [DUR_MS_W-1:0] ms_left_q, ms_left_d;

	logic                result_valid_q;
	result_t             result_q;

	logic                pop;
	logic                byte_take;
	logic                start_grp;
	logic                start_tone;
	logic                start_rest;
	logic                start_pause;
	logic [HALF_W:0]     hp_inc;
	logic                hp_done;
	logic [DUR_US_W-1:0] elapsed_sum;
	logic                tone_more;
	logic [US_W:0]       us_inc;
	logic                ms_wrap;
	logic [DUR_MS_W-1:0] ms_dec;
	logic                ms_end;
	phase_t              pause_phase;

	assign cls_ready = !result_valid_q || result_ready;
	assign pop       = cls_valid && cls_ready;

	assign byte_take   = !cls.tick && (phase_q == PH_IDLE);
	assign start_grp   = byte_take && !cls.end_mark && (pos_q != POS_NOTE) && (pos_q != POS_DUR);
	assign start_tone  = start_grp && (period_q != '0) && (dur_ms_q != '0);
	assign start_rest  = start_grp && (period_q == '0) && (dur_ms_q != '0);
	assign start_pause = start_grp && (dur_ms_q == '0);

	// Half-period counting; an odd period loses its odd microsecond per period.
	assign hp_inc      = {1'b0, half_q} + 1'b1;
	assign hp_done     = hp_inc >= {1'b0, period_q[PERIOD_W-1:1]};
	assign elapsed_sum = elapsed_q + DUR_US_W'(period_q);
	assign tone_more   = elapsed_sum < dur_us_q;

	// Millisecond counting for rests and pauses.
	assign us_inc  = {1'b0, us_q} + 1'b1;
	assign ms_wrap = us_inc >= US_PER_MS;
	assign ms_dec  = (ms_left_q != '0) ? ms_left_q - 1'b1 : '0;
	assign ms_end  = (ms_dec == '0);

	assign pause_phase = (pause_q != '0) ? PH_PAUSE : PH_IDLE;

	// Next play phase.
	always_comb begin
		phase_d = phase_q;
		if (pop) begin
			if (!cls.tick) begin
				if (start_tone) begin
					phase_d = PH_HIGH;
				end else if (start_rest) begin
					phase_d = PH_REST;
				end else if (start_pause) begin
					phase_d = (cls.pause_ms != '0) ? PH_PAUSE : PH_IDLE;
				end
			end else begin
				unique case (phase_q)
					PH_HIGH: begin
						if (hp_done) phase_d = PH_LOW;
					end
					PH_LOW: begin
						if (hp_done) phase_d = tone_more ? PH_HIGH : pause_phase;
					end
					PH_REST: begin
						if (ms_wrap && ms_end) phase_d = pause_phase;
					end
					PH_PAUSE: begin
						if (ms_wrap && ms_end) phase_d = PH_IDLE;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// Group fields, counters and the pin.
	always_comb begin
		pos_d     = pos_q;
		pin_d     = pin_q;
		period_d  = period_q;
		dur_ms_d  = dur_ms_q;
		dur_us_d  = dur_us_q;
		pause_d   = pause_q;
		half_d    = half_q;
		elapsed_d = elapsed_q;
		us_d      = us_q;
		ms_left_d = ms_left_q;
		if (pop) begin
			if (!cls.tick) begin
				if (byte_take) begin
					if (cls.end_mark) begin
						pos_d = POS_NOTE;
					end else begin
						unique case (pos_q)
							POS_NOTE: begin
								period_d = cls.period_us;
								pos_d    = POS_DUR;
							end
							POS_DUR: begin
								dur_ms_d = cls.dur_ms;
								dur_us_d = cls.dur_us;
								pos_d    = POS_PAUSE;
							end
							default: begin
								pause_d   = cls.pause_ms;
								pos_d     = POS_NOTE;
								elapsed_d = '0;
								half_d    = '0;
								us_d      = '0;
								if (start_tone) begin
									pin_d = 1'b1;
								end else if (start_rest) begin
									pin_d     = 1'b0;
									ms_left_d = dur_ms_q;
								end else begin
									pin_d     = 1'b0;
									ms_left_d = DUR_MS_W'(cls.pause_ms);
								end
							end
						endcase
					end
				end
			end else begin
				unique case (phase_q)
					PH_HIGH: begin
						half_d = hp_done ? '0 : hp_inc[HALF_W-1:0];
						if (hp_done) pin_d = 1'b0;
					end
					PH_LOW: begin
						half_d = hp_done ? '0 : hp_inc[HALF_W-1:0];
						if (hp_done) begin
							elapsed_d = elapsed_sum;
							if (tone_more) begin
								pin_d = 1'b1;
							end else begin
								pin_d     = 1'b0;
								us_d      = '0;
								ms_left_d = DUR_MS_W'(pause_q);
							end
						end
					end
					PH_REST, PH_PAUSE: begin
						if (ms_wrap) begin
							us_d      = '0;
							ms_left_d = ms_dec;
							if (ms_end) begin
								pin_d = 1'b0;
								if (phase_q == PH_REST) ms_left_d = DUR_MS_W'(pause_q);
							end
						end else begin
							us_d = us_inc[US_W-1:0];
						end
					end
					default: pin_d = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= POS_NOTE;
			pin_q     <= 1'b0;
			period_q  <= '0;
			dur_ms_q  <= '0;
			dur_us_q  <= '0;
			pause_q   <= '0;
			half_q    <= '0;
			elapsed_q <= '0;
			us_q      <= '0;
			ms_left_q <= '0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			pin_q     <= pin_d;
			period_q  <= period_d;
			dur_ms_q  <= dur_ms_d;
			dur_us_q  <= dur_us_d;
			pause_q   <= pause_d;
			half_q    <= half_d;
			elapsed_q <= elapsed_d;
			us_q      <= us_d;
			ms_left_q <= ms_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cls_ready) begin
			result_valid_q <= cls_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.speaker_level <= pin_d;
			result_q.busy_res      <= (phase_d != PH_IDLE);
			result_q.byte_rejected <= !cls.tick && (phase_q != PH_IDLE);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

[rtl/core/melody_string_tone_player.sv]
// Square-wave melody player, top level. Transactions on the item channel are
// either a song byte or a one-microsecond tick; every item yields exactly one
// result transaction carrying the speaker level, a busy flag and a flag for a
// byte dropped while a note, rest or pause was playing. Bytes are taken in
// groups of three (note letter, duration digit, pause mark) and a zero byte
// discards a partial group. The block sustains one item per clock cycle on
// both channels: the front end decodes each byte in two pipeline stages (a
// table look-up and a digit-by-step multiplication, then the conversion of
// the duration to microseconds), a queue of QUEUE_DEPTH entries sits between
// front and back, and the back end applies one item per cycle to the play
// state and loads the result register while results are taken. Results
// pass the front-end stages, the queue and the result register. The two
// configuration registers (default duration at byte address 0, duration step
// at 4) are read and written over the APB-style port, which never inserts
// wait states; they are meant to be written only while no item is in flight.
// The file depends on msp_pkg, msp_regs, msp_front, msp_queue and msp_back.
`default_nettype none

module melody_string_tone_player
	import msp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// Item channel: song bytes and microsecond ticks.
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,

	// Result channel: one transaction per item.
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,

	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t cfg;

	// Front end to queue.
	logic fq_valid;
	logic fq_ready;
	cls_t fq_data;

	// Queue to back end.
	logic qb_valid;
	logic qb_ready;
	cls_t qb_data;

	// Registers are word aligned, so the word index is the third address bit.
	msp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.reg_index (paddr[2]),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg)
	);

	// The front end classifies every byte for all three group positions at
	// once; the back end picks the field that its group position asks for.
	msp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg        (cfg),
		.cls_valid  (fq_valid),
		.cls_ready  (fq_ready),
		.cls        (fq_data)
	);

	msp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	// The back end holds all play state; it stalls only when its result
	// register is full and the consumer is not taking the transaction.
	msp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cls_valid    (qb_valid),
		.cls_ready    (qb_ready),
		.cls          (qb_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

[rtl/core/msp_checker.sv]
// Port-level checks of the melody player, bound to the top level.
// Depends on msp_pkg and the assertion macro header.
`default_nettype none
`include "melody_string_tone_player_assert.svh"

module msp_checker
	import msp_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// A stalled result transaction keeps its contents.
	`MSP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// The pin is never driven high while the player is idle.
	`MSP_ASSERT_NOW(a_idle_pin_low, result_valid && !result.busy_res, !result.speaker_level)

	// A dropped byte leaves the player busy.
	`MSP_ASSERT_NOW(a_reject_busy, result_valid && result.byte_rejected, result.busy_res)

endmodule

bind melody_string_tone_player msp_checker u_msp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
